[rtl/tkal_pkg.sv]
// ----------------------------------------------------------------------------
// tkal_pkg
// Shared types, field widths and helpers for the k-th ancestor engine.
// ----------------------------------------------------------------------------
package tkal_pkg;

   // Default sizing of the jump table
   localparam int unsigned DefMaxNodes = 1024;
   localparam int unsigned DefLevels   = 11;

   // Transaction field widths
   localparam int unsigned ActionW  = 2;
   localparam int unsigned NodeW    = 10;
   localparam int unsigned DistW    = 11;
   localparam int unsigned DistPosW = $clog2(DistW);
   localparam int unsigned CountW   = 11;
   localparam int unsigned AncW     = 10;

   localparam logic [CountW-1:0] CountReset = CountW'(1024);

   typedef enum logic [ActionW-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_BUILD = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BUILD_RD,
      ST_BUILD_LINK,
      ST_BUILD_WR,
      ST_QUERY,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef struct packed {
      logic            found;
      logic [AncW-1:0] ancestor;
   } rsp_data_type;

   // Position of the lowest set bit of a distance (0 when none is set)
   function automatic logic [DistPosW-1:0] lowest_set(input logic [DistW-1:0] d);
      logic [DistPosW-1:0] pos;
      pos = '0;
      for (int i = DistW - 1; i >= 0; i--) begin
         if (d[i]) begin
            pos = DistPosW'(i);
         end
      end
      return pos;
   endfunction

endpackage

[rtl/tkal_if.sv]
// ----------------------------------------------------------------------------
// tkal_if
// Valid/ready channels of the k-th ancestor engine: request, response, CSR.
// ----------------------------------------------------------------------------
interface tkal_req_if
   import tkal_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [ActionW-1:0] action;
   logic [NodeW-1:0]   node;
   logic [NodeW-1:0]   parent;
   logic [DistW-1:0]   distance;

   modport source (output valid, action, node, parent, distance, input ready);
   modport sink   (input valid, action, node, parent, distance, output ready);
endinterface

interface tkal_rsp_if
   import tkal_pkg::*;
;
   logic            valid;
   logic            ready;
   logic            found;
   logic [AncW-1:0] ancestor;

   modport source (output valid, found, ancestor, input ready);
   modport sink   (input valid, found, ancestor, output ready);
endinterface

interface tkal_csr_if
   import tkal_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [CountW-1:0] node_count;

   modport source (output valid, node_count, input ready);
   modport sink   (input valid, node_count, output ready);
endinterface

[rtl/tkal_jump_mem.sv]
// ----------------------------------------------------------------------------
// tkal_jump_mem
// Jump table storage: one write port, one read port with registered data.
// A read that hits the entry written on the same edge returns the new data.
// ----------------------------------------------------------------------------
module tkal_jump_mem
   import tkal_pkg::*;
#(
   parameter int unsigned ADDR_W = 14,
   parameter int unsigned DATA_W = 11,
   parameter int unsigned DEPTH  = 11264
) (
   input  logic              clock,
   input  logic              reset,
   input  mem_ctl_type       mem_ctl,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] q_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic              fwd_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         q_ff        <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (mem_ctl.rd_en) begin
         fwd_ff <= mem_ctl.wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : q_ff;

endmodule

[rtl/tkal_ctrl.sv]
// ----------------------------------------------------------------------------
// tkal_ctrl
// Sequencer: clearing pass, parent loads, level-by-level build and the
// bit-by-bit ancestor walk, all through the jump table memory.
// ----------------------------------------------------------------------------
module tkal_ctrl
   import tkal_pkg::*;
#(
   parameter int unsigned MAX_NODES = DefMaxNodes,
   parameter int unsigned LEVELS    = DefLevels
) (
   input  logic              clock,
   input  logic              reset,
   tkal_req_if.sink          req_bus,
   input  logic [CountW-1:0] node_count,
   input  logic              out_free,
   output logic              res_push,
   output rsp_data_type      res,
   output mem_ctl_type       mem_ctl,
   output logic [$clog2(LEVELS)+$clog2(MAX_NODES)-1:0] rd_addr,
   output logic [$clog2(LEVELS)+$clog2(MAX_NODES)-1:0] wr_addr,
   output logic [$clog2(MAX_NODES):0]                  wr_data,
   input  logic [$clog2(MAX_NODES):0]                  rd_data
);

   localparam int unsigned NODE_W = $clog2(MAX_NODES);
   localparam int unsigned LVL_W  = $clog2(LEVELS);
   localparam int unsigned ADDR_W = LVL_W + NODE_W;
   localparam int unsigned DEPTH  = LEVELS << NODE_W;
   localparam int unsigned LIM_W  = $clog2(MAX_NODES + 1);

   state_type         state_ff, state_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [NODE_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [DistW-1:0]  dist_ff, dist_in;
   logic              e_valid_ff, e_valid_in;
   rsp_data_type      res_ff, res_in;

   logic                load_ok, start_ok, first_lvl_ok, walk_lvl_ok;
   logic [DistPosW-1:0] q_pos, w_pos;
   logic [DistW-1:0]    q_rest, w_rest;
   logic [LIM_W-1:0]    build_lim;
   logic                last_j, last_lvl;
   logic                rd_valid;
   logic [NODE_W-1:0]   rd_idx;

   // Request decode
   assign load_ok = (req_bus.node != '0)
                 && (32'(req_bus.node) < 32'(MAX_NODES))
                 && (32'(req_bus.parent) < 32'(MAX_NODES));
   assign start_ok     = 32'(req_bus.node) < 32'(MAX_NODES);
   assign q_pos        = lowest_set(req_bus.distance);
   assign q_rest       = req_bus.distance & (req_bus.distance - DistW'(1));
   assign first_lvl_ok = 32'(q_pos) < 32'(LEVELS);

   // Walk decode on the remaining distance bits
   assign w_pos       = lowest_set(dist_ff);
   assign w_rest      = dist_ff & (dist_ff - DistW'(1));
   assign walk_lvl_ok = 32'(w_pos) < 32'(LEVELS);

   assign rd_valid = rd_data[NODE_W];
   assign rd_idx   = rd_data[NODE_W-1:0];

   // Build bound and loop ends
   assign build_lim = (32'(node_count) > 32'(MAX_NODES)) ? LIM_W'(MAX_NODES)
                                                         : LIM_W'(node_count);
   assign last_j   = (LIM_W'(j_ff) + LIM_W'(1)) == build_lim;
   assign last_lvl = lvl_ff == LVL_W'(LEVELS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         lvl_ff   <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         lvl_ff   <= lvl_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff    <= dist_in;
      e_valid_ff <= e_valid_in;
      res_ff     <= res_in;
   end

   // Next state and sequencer registers
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      lvl_in     = lvl_ff;
      j_in       = j_ff;
      dist_in    = dist_ff;
      e_valid_in = e_valid_ff;
      res_in     = res_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               case (req_bus.action)
                  ACT_BUILD: begin
                     if (build_lim != '0) begin
                        lvl_in   = LVL_W'(1);
                        j_in     = '0;
                        state_in = ST_BUILD_RD;
                     end
                  end
                  ACT_QUERY: begin
                     dist_in = q_rest;
                     if (!start_ok) begin
                        res_in   = '{found: 1'b0, ancestor: '0};
                        state_in = ST_RESULT;
                     end else if (req_bus.distance == '0) begin
                        res_in   = '{found: 1'b1, ancestor: AncW'(req_bus.node)};
                        state_in = ST_RESULT;
                     end else if (!first_lvl_ok) begin
                        res_in   = '{found: 1'b0, ancestor: '0};
                        state_in = ST_RESULT;
                     end else begin
                        state_in = ST_QUERY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_BUILD_RD: begin
            state_in = ST_BUILD_LINK;
         end
         ST_BUILD_LINK: begin
            e_valid_in = rd_valid;
            state_in   = ST_BUILD_WR;
         end
         ST_BUILD_WR: begin
            state_in = ST_BUILD_LINK;
            if (last_j) begin
               j_in = '0;
               if (last_lvl) begin
                  state_in = ST_IDLE;
               end else begin
                  lvl_in = lvl_ff + LVL_W'(1);
               end
            end else begin
               j_in = j_ff + NODE_W'(1);
            end
         end
         ST_QUERY: begin
            if (!rd_valid) begin
               res_in   = '{found: 1'b0, ancestor: '0};
               state_in = ST_RESULT;
            end else if (dist_ff == '0) begin
               res_in   = '{found: 1'b1, ancestor: AncW'(rd_idx)};
               state_in = ST_RESULT;
            end else if (!walk_lvl_ok) begin
               res_in   = '{found: 1'b0, ancestor: '0};
               state_in = ST_RESULT;
            end else begin
               dist_in = w_rest;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory accesses, handshake and result hand-off
   always_comb begin
      mem_ctl       = '0;
      rd_addr       = '0;
      wr_addr       = '0;
      wr_data       = '0;
      req_bus.ready = 1'b0;
      res_push      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = clr_ff;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid && (req_bus.action == ACT_LOAD) && load_ok) begin
               mem_ctl.wr_en = 1'b1;
               wr_addr       = {LVL_W'(0), NODE_W'(req_bus.node)};
               wr_data       = {1'b1, NODE_W'(req_bus.parent)};
            end
            if (req_bus.valid && (req_bus.action == ACT_QUERY) && start_ok
                && (req_bus.distance != '0) && first_lvl_ok) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = {LVL_W'(q_pos), NODE_W'(req_bus.node)};
            end
         end
         ST_BUILD_RD: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = {lvl_ff - LVL_W'(1), j_ff};
         end
         ST_BUILD_LINK: begin
            if (rd_valid) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = {lvl_ff - LVL_W'(1), rd_idx};
            end
         end
         ST_BUILD_WR: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = {lvl_ff, j_ff};
            wr_data       = e_valid_ff ? rd_data : '0;
            // Overlap the first read of the next entry with this write
            if (!(last_j && last_lvl)) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = last_j ? {lvl_ff, NODE_W'(0)}
                                      : {lvl_ff - LVL_W'(1), j_ff + NODE_W'(1)};
            end
         end
         ST_QUERY: begin
            if (rd_valid && (dist_ff != '0) && walk_lvl_ok) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = {LVL_W'(w_pos), rd_idx};
            end
         end
         ST_RESULT: begin
            res_push = out_free;
         end
         default: ;
      endcase
   end

   assign res = res_ff;

endmodule

[rtl/tree_kth_ancestor_lifting.sv]
// ----------------------------------------------------------------------------
// tree_kth_ancestor_lifting
// K-th ancestor engine for a rooted tree using a binary lifting jump table.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 transaction payload
//   req_bus   in         valid/ready               action, node, parent, distance
//   rsp_bus   out        valid/ready               found, ancestor
//   csr_bus   in         valid/ready (ready = 1)   node_count
//
// Work: a valid load is a single table write; a build reads the jump table twice
// per entry for each of levels 1 to LEVELS-1, over min(node_count, MAX_NODES)
// entries (nothing when the bound is zero); a query does one dependent table
// read per distance bit that is walked.
// Reset: a clearing pass writes all LEVELS * 2**clog2(MAX_NODES) table entries
// (11264 at the default size) to none, with req_bus.ready low.
// Stalls: one transaction is processed at a time; a finished response waits
// in the output register, and only a query that finishes while it is still
// full holds until rsp_bus.ready drains it. Loads and builds proceed freely.
// ----------------------------------------------------------------------------
module tree_kth_ancestor_lifting
   import tkal_pkg::*;
#(
   parameter int unsigned MAX_NODES = DefMaxNodes,
   parameter int unsigned LEVELS    = DefLevels
) (
   input  logic        clock,
   input  logic        reset,
   tkal_req_if.sink    req_bus,
   tkal_rsp_if.source  rsp_bus,
   tkal_csr_if.sink    csr_bus
);

   localparam int unsigned NODE_W = $clog2(MAX_NODES);
   localparam int unsigned LVL_W  = $clog2(LEVELS);
   localparam int unsigned ADDR_W = LVL_W + NODE_W;
   localparam int unsigned DATA_W = NODE_W + 1;
   localparam int unsigned DEPTH  = LEVELS << NODE_W;

   logic [CountW-1:0] node_count_ff;
   logic              rsp_valid_ff;
   rsp_data_type      rsp_data_ff;

   logic              out_free;
   logic              res_push;
   rsp_data_type      res;
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;

   // Node count register: the user must write it only while the engine is idle; not enforced here
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CountReset;
      end else if (csr_bus.valid) begin
         node_count_ff <= csr_bus.node_count;
      end
   end

   // Output register: accept a new response when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.found    = rsp_data_ff.found;
   assign rsp_bus.ancestor = rsp_data_ff.ancestor;

   // Sequencer: clear, load, build, walk
   tkal_ctrl #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .node_count (node_count_ff),
      .out_free   (out_free),
      .res_push   (res_push),
      .res        (res),
      .mem_ctl    (mem_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_data    (rd_data)
   );

   // Jump table: level in the upper address bits, node in the lower
   tkal_jump_mem #(
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W),
      .DEPTH  (DEPTH)
   ) u_jump_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

[rtl/tkal_checker.sv]
// ----------------------------------------------------------------------------
// tkal_checker
// Port-level checks of the k-th ancestor engine, bound to the top level.
// ----------------------------------------------------------------------------
module tkal_checker
   import tkal_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic            rsp_found,
   input logic [AncW-1:0] rsp_ancestor
);

   // Hold a response until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Hold the payload of a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_ancestor))
      else $error("response payload changed while stalled");

   // Not-found responses carry a zero ancestor
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_ancestor == '0)
      else $error("not-found response with nonzero ancestor");

   // Stay closed to requests when reset is released, as the clearing pass begins
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request accepted during clearing pass");

   // A response never follows its request on the very next edge
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response raised one cycle after a request");

endmodule

bind tree_kth_ancestor_lifting tkal_checker u_tkal_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_found    (rsp_bus.found),
   .rsp_ancestor (rsp_bus.ancestor)
);
